// ===== rtl/dcfx_pkg.sv =====
// Package for the checked decimal fixed-point ALU.
// Holds command and status codes, the decimal scale and the shared pipeline types.
// No dependencies.
package dcfx_pkg;

  localparam logic [63:0] DecimalScale = 64'd100000000;
  localparam logic [63:0] PosMax       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegMaxMag    = 64'h8000_0000_0000_0000;
  localparam int          DivSteps     = 64;

  localparam logic [2:0] CmdAdd = 3'd0;
  localparam logic [2:0] CmdSub = 3'd1;
  localparam logic [2:0] CmdMul = 3'd2;
  localparam logic [2:0] CmdDiv = 3'd3;
  localparam logic [2:0] CmdI2F = 3'd4;
  localparam logic [2:0] CmdF2I = 3'd5;

  localparam logic [1:0] StOk  = 2'd0;
  localparam logic [1:0] StOvf = 2'd1;
  localparam logic [1:0] StDbz = 2'd2;

  typedef struct packed {
    logic        neg;
    logic        done;
    logic [1:0]  status;
    logic [63:0] value;
  } meta_t;

endpackage

// ===== rtl/dcfx_front.sv =====
// Front end: decode, magnitude split, 64x64 multiply in 32-bit partial products.
// Three register stages; does add/sub; emits numerator, denominator, item tag.
// Depends on dcfx_pkg.
module dcfx_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2:0]          cmd_i,
  input  logic [63:0]         left_operand_i,
  input  logic [63:0]         right_operand_i,
  output logic                valid_o,
  output logic [63:0]         num_o,
  output logic [63:0]         den_o,
  output dcfx_pkg::meta_t     meta_o
);
  import dcfx_pkg::*;

  logic        v1_q, v2_q, v3_q;
  logic [63:0] x_d, y_d, den_d, x_q, y_q;
  logic [63:0] den1_q, den2_q, den3_q;
  logic        limhi_d, limhi1_q, limhi2_q;
  meta_t       m_d, m1_q, m2_q, m3_d, m3_q;
  logic [63:0] pll_q, plh_q, phl_q, phh_q, num3_q;
  logic        sa, sb;
  logic [63:0] ma, mb, sum;
  logic [127:0] prod;
  logic [63:0] lim;
  logic        pre_ovf;

  always_comb begin
    sa = left_operand_i[63];
    sb = right_operand_i[63];
    ma = sa ? (64'd0 - left_operand_i) : left_operand_i;
    mb = sb ? (64'd0 - right_operand_i) : right_operand_i;
    x_d = ma;
    y_d = DecimalScale;
    den_d = DecimalScale;
    limhi_d = 1'b0;
    sum = '0;
    m_d = '{neg: sa ^ sb, done: 1'b0, status: StOk, value: 64'd0};
    unique case (cmd_i)
      CmdAdd: begin
        sum = left_operand_i + right_operand_i;
        m_d.done = 1'b1;
        if (sa == sb && sum[63] != sa) m_d.status = StOvf;
        else m_d.value = sum;
      end
      CmdSub: begin
        sum = left_operand_i - right_operand_i;
        m_d.done = 1'b1;
        if (sa != sb && sum[63] != sa) m_d.status = StOvf;
        else m_d.value = sum;
      end
      CmdMul: begin
        y_d = mb;
      end
      CmdDiv: begin
        den_d = mb;
        if (right_operand_i == 64'd0) begin
          m_d.done = 1'b1;
          m_d.status = StDbz;
        end
      end
      CmdI2F: begin
        den_d = 64'd1;
        m_d.neg = sa;
        limhi_d = sa;
      end
      CmdF2I: begin
        y_d = 64'd1;
        m_d.neg = sa;
        limhi_d = 1'b1;
      end
      default: begin
        m_d.done = 1'b1;
        m_d.status = StOvf;
      end
    endcase
  end

  always_comb begin
    prod = {phh_q, 64'd0} + {32'd0, plh_q, 32'd0} + {32'd0, phl_q, 32'd0}
         + {64'd0, pll_q};
    lim = limhi2_q ? NegMaxMag : PosMax;
    pre_ovf = (prod[127:64] != 64'd0) || (prod[63:0] > lim);
    m3_d = m2_q;
    if (!m2_q.done && pre_ovf) begin
      m3_d.done   = 1'b1;
      m3_d.status = StOvf;
      m3_d.value  = 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q      <= x_d;
      y_q      <= y_d;
      den1_q   <= den_d;
      limhi1_q <= limhi_d;
      m1_q     <= m_d;
      pll_q    <= 64'(x_q[31:0]) * 64'(y_q[31:0]);
      plh_q    <= 64'(x_q[31:0]) * 64'(y_q[63:32]);
      phl_q    <= 64'(x_q[63:32]) * 64'(y_q[31:0]);
      phh_q    <= 64'(x_q[63:32]) * 64'(y_q[63:32]);
      den2_q   <= den1_q;
      limhi2_q <= limhi1_q;
      m2_q     <= m1_q;
      num3_q   <= prod[63:0];
      den3_q   <= den2_q;
      m3_q     <= m3_d;
    end
  end

  assign valid_o = v3_q;
  assign num_o   = num3_q;
  assign den_o   = den3_q;
  assign meta_o  = m3_q;

endmodule

// ===== rtl/dcfx_div_step.sv =====
// One restoring-division step: one quotient bit per stage.
// Shifts the numerator into the remainder and trial-subtracts the divisor.
// Depends on dcfx_pkg.
module dcfx_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [63:0]         rem_i,
  input  logic [63:0]         nq_i,
  input  logic [63:0]         den_i,
  input  dcfx_pkg::meta_t     meta_i,
  output logic                valid_o,
  output logic [63:0]         rem_o,
  output logic [63:0]         nq_o,
  output logic [63:0]         den_o,
  output dcfx_pkg::meta_t     meta_o
);
  import dcfx_pkg::*;

  logic        v_q;
  logic [63:0] rem_q, nq_q, den_q;
  meta_t       m_q;
  logic [63:0] t;
  logic        ge;

  always_comb begin
    t  = {rem_i[62:0], nq_i[63]};
    ge = (t >= den_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (en_i) v_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= ge ? (t - den_i) : t;
      nq_q  <= {nq_i[62:0], ge};
      den_q <= den_i;
      m_q   <= meta_i;
    end
  end

  assign valid_o = v_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign den_o   = den_q;
  assign meta_o  = m_q;

endmodule

// ===== rtl/dcfx_round.sv =====
// Output stage: round half away from zero, range check, sign restore.
// Holds the result word until the sink takes it.
// Depends on dcfx_pkg.
module dcfx_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [63:0]         rem_i,
  input  logic [63:0]         quo_i,
  input  logic [63:0]         den_i,
  input  dcfx_pkg::meta_t     meta_i,
  output logic                valid_o,
  output logic [63:0]         result_value_o,
  output logic [1:0]          status_o
);
  import dcfx_pkg::*;

  logic        v_q;
  logic [63:0] val_q, val_d, q1;
  logic [1:0]  st_q, st_d;
  logic        up, ovf;

  always_comb begin
    up  = (rem_i != 64'd0) && (rem_i >= (den_i - rem_i));
    q1  = quo_i + 64'(up);
    ovf = meta_i.neg ? (q1 > NegMaxMag) : (q1 > PosMax);
    if (meta_i.done) begin
      val_d = meta_i.value;
      st_d  = meta_i.status;
    end else if (ovf) begin
      val_d = 64'd0;
      st_d  = StOvf;
    end else begin
      val_d = meta_i.neg ? (64'd0 - q1) : q1;
      st_d  = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (en_i) v_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
      st_q  <= st_d;
    end
  end

  assign valid_o        = v_q;
  assign result_value_o = val_q;
  assign status_o       = st_q;

endmodule

// ===== rtl/checked_decimal_fixed_point_alu.sv =====
// Channel  | dir | tdata fields (low bit up)                          | tuser
// s_axis   | in  | cmd[2:0], left_operand[66:3], right_operand[130:67] | -
// m_axis   | out | result_value[63:0], status[65:64]                   | -
// Pipeline: 3 front stages, 64 division stages, 1 output stage.
// Accepts one word per cycle unless stalled; the 64-step divider sets the latency.
// Reset clears all valid bits; data registers are not reset.
// A stalled output word freezes the whole pipeline; nothing is lost or repeated.
// Top level; depends on dcfx_pkg, dcfx_front, dcfx_div_step, dcfx_round.
module checked_decimal_fixed_point_alu (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [135:0] s_axis_tdata_i,   // cmd, left_operand, right_operand, zero pad
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [71:0]  m_axis_tdata_o    // result_value, status, zero pad
);
  import dcfx_pkg::*;

  logic        en;
  logic        dv   [DivSteps+1];
  logic [63:0] drem [DivSteps+1];
  logic [63:0] dnq  [DivSteps+1];
  logic [63:0] dden [DivSteps+1];
  meta_t       dmeta[DivSteps+1];
  logic [63:0] res_val;
  logic [1:0]  res_st;

  assign en = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign drem[0] = 64'd0;

  dcfx_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (s_axis_tvalid_i),
    .cmd_i           (s_axis_tdata_i[2:0]),
    .left_operand_i  (s_axis_tdata_i[66:3]),
    .right_operand_i (s_axis_tdata_i[130:67]),
    .valid_o         (dv[0]),
    .num_o           (dnq[0]),
    .den_o           (dden[0]),
    .meta_o          (dmeta[0])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    dcfx_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[i]),
      .rem_i   (drem[i]),
      .nq_i    (dnq[i]),
      .den_i   (dden[i]),
      .meta_i  (dmeta[i]),
      .valid_o (dv[i+1]),
      .rem_o   (drem[i+1]),
      .nq_o    (dnq[i+1]),
      .den_o   (dden[i+1]),
      .meta_o  (dmeta[i+1])
    );
  end

  dcfx_round u_round (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (dv[DivSteps]),
    .rem_i          (drem[DivSteps]),
    .quo_i          (dnq[DivSteps]),
    .den_i          (dden[DivSteps]),
    .meta_i         (dmeta[DivSteps]),
    .valid_o        (m_axis_tvalid_o),
    .result_value_o (res_val),
    .status_o       (res_st)
  );

  assign m_axis_tdata_o = {6'd0, res_st, res_val};

`ifndef SYNTH
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_st == StOk || res_st == StOvf || res_st == StDbz))
    else $error("invalid status code");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_st != StOk) |-> (res_val == 64'd0))
    else $error("failed result carries nonzero value");
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a held output word");
`endif

endmodule
